// ----- design/swbs_pkg.sv -----
// package for the sorted word binary search block
// types, constants and codes shared by the interfaces, controller and datapath
`default_nettype none

package swbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int WORD_CHARS  = 8;

    localparam int WORD_W = 64;
    localparam int OP_W   = 2;
    localparam int POS_W  = 10;
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    // characters beyond WORD_CHARS are forced to zero
    localparam logic [WORD_W-1:0] KEEP_MASK = {WORD_W{1'b1}} << (WORD_W - 8 * WORD_CHARS);

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_SEARCH = 2'd1,
        OP_CLEAR  = 2'd2
    } t_swbs_op;

    typedef enum logic [0:0] {
        S_IDLE   = 1'b0,
        S_SEARCH = 1'b1
    } t_swbs_state;

    typedef struct packed {
        logic append;
        logic clear;
        logic start;
        logic step;
        logic finish;
    } t_swbs_cmd;

    typedef struct packed {
        logic done;
        logic out_free;
    } t_swbs_sts;

endpackage

`default_nettype wire

// ----- design/swbs_if.sv -----
// request and result channel interfaces
// depends on swbs_pkg for field widths
`default_nettype none

interface swbs_req_if import swbs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] word;

    modport source (output valid, output op, output word, input ready);
    modport sink   (input valid, input op, input word, output ready);
endinterface

interface swbs_rsp_if import swbs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

`default_nettype wire

// ----- design/swbs_ctrl.sv -----
// controller for the sorted word binary search block
// decodes requests and sequences the probes; depends on swbs_pkg
`default_nettype none

module swbs_ctrl import swbs_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    input  wire logic [OP_W-1:0] i_op,
    output logic                 o_req_ready,
    input  wire t_swbs_sts       i_sts,
    output t_swbs_cmd            o_cmd
);

    t_swbs_state r_state;
    t_swbs_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    case (i_op)
                        OP_APPEND: o_cmd.append = 1'b1;
                        OP_CLEAR:  o_cmd.clear  = 1'b1;
                        OP_SEARCH: begin
                            o_cmd.start = 1'b1;
                            n_state     = S_SEARCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_SEARCH: begin
                if (!i_sts.done) begin
                    o_cmd.step = 1'b1;
                end else if (i_sts.out_free) begin
                    // result slot is free, hand over the result and return to idle for the next request
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_start_enters_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> r_state == S_SEARCH)
        else $error("search start did not enter the search state");

    a_finish_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free && i_sts.done)
        else $error("result issued while the result slot was busy");

    a_finish_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == S_IDLE)
        else $error("controller did not return to idle after a result");

endmodule

`default_nettype wire

// ----- design/swbs_dp.sv -----
// datapath for the sorted word binary search block
// word table memory, entry count, search bounds and result register; depends on swbs_pkg
`default_nettype none

module swbs_dp import swbs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [WORD_W-1:0] i_word,
    input  wire t_swbs_cmd         i_cmd,
    output t_swbs_sts              o_sts,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_found,
    output logic [POS_W-1:0]       o_position
);

    logic [WORD_W-1:0] r_mem [TABLE_DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    logic [CNT_W-1:0]  r_count;
    logic [WORD_W-1:0] r_key;
    logic [CNT_W-1:0]  r_lo;
    logic [CNT_W-1:0]  r_hi1;      // exclusive upper bound
    logic [ADDR_W-1:0] r_mid;

    logic              r_out_valid;
    logic              r_found;
    logic [POS_W-1:0]  r_position;

    logic [WORD_W-1:0] w_word_kept;
    logic [CNT_W-1:0]  w_mid_ext;
    logic [CNT_W:0]    w_sum_left;
    logic [CNT_W:0]    w_sum_right;
    logic [ADDR_W-1:0] w_mid_left;
    logic [ADDR_W-1:0] w_mid_right;
    logic [ADDR_W-1:0] w_mid_first;
    logic              w_lt;
    logic              w_eq;
    logic              w_empty;
    logic              w_left_empty;
    logic              w_right_empty;
    logic              w_hit;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_can_append;

    assign w_word_kept  = i_word & KEEP_MASK;
    assign w_can_append = r_count < CNT_W'(TABLE_DEPTH);

    assign w_mid_ext   = CNT_W'(r_mid);
    assign w_mid_first = ADDR_W'((r_count - CNT_W'(1)) >> 1);
    // next probe if going left (hi1 = mid) or right (lo = mid + 1)
    assign w_sum_left  = {1'b0, r_lo} + {1'b0, w_mid_ext} - (CNT_W + 1)'(1);
    assign w_sum_right = {1'b0, w_mid_ext} + {1'b0, r_hi1};
    assign w_mid_left  = ADDR_W'(w_sum_left >> 1);
    assign w_mid_right = ADDR_W'(w_sum_right >> 1);

    assign w_lt          = r_key < r_rd_data;
    assign w_eq          = r_key == r_rd_data;
    assign w_empty       = r_hi1 == '0;
    assign w_left_empty  = r_lo >= w_mid_ext;
    assign w_right_empty = ({1'b0, w_mid_ext} + (CNT_W + 1)'(1)) >= {1'b0, r_hi1};
    assign w_hit         = !w_empty && w_eq;

    assign o_sts.done     = w_empty || w_eq || (w_lt ? w_left_empty : w_right_empty);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign w_rd_en   = (i_cmd.start && r_count != '0) || i_cmd.step;
    assign w_rd_addr = i_cmd.start ? w_mid_first : (w_lt ? w_mid_left : w_mid_right);

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && w_can_append) begin
            r_mem[r_count[ADDR_W-1:0]] <= w_word_kept;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.append && w_can_append) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key <= w_word_kept;
            r_lo  <= '0;
            r_hi1 <= r_count;
            r_mid <= w_mid_first;
        end else if (i_cmd.step) begin
            if (w_lt) begin
                r_hi1 <= w_mid_ext;
                r_mid <= w_mid_left;
            end else begin
                r_lo  <= w_mid_ext + CNT_W'(1);
                r_mid <= w_mid_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_found    <= w_hit;
            r_position <= w_hit ? POS_W'(r_mid) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_position;

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_probe_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step || i_cmd.finish) && !w_empty |-> r_lo <= w_mid_ext && w_mid_ext < r_hi1)
        else $error("probe index outside the search bounds");

    a_miss_position_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_found |-> r_position == '0)
        else $error("position not zero on a miss");

endmodule

`default_nettype wire

// ----- design/sorted_word_binary_search_top.sv -----
// channel      | dir | fields          | notes
// i_req        | in  | op, word        | op 0 append, 1 search, 2 clear, 3 ignored
// o_rsp        | out | found, position | one result per search request
//
// append, clear and ignored requests give no result.
// a search first issues the table read for the middle entry, then steps through the probes
// (each one read of the table ram and one 64-bit compare) until a hit or an empty range.
// reset clears the entry count and the result slot; the table contents are kept.
// a finished result waits in the output register; the next request is taken
// once the search that made it has handed it over.
// top level of the sorted word binary search block
// depends on swbs_pkg, swbs_if, swbs_ctrl, swbs_dp
`default_nettype none

module sorted_word_binary_search_top import swbs_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    swbs_req_if.sink    i_req,
    swbs_rsp_if.source  o_rsp
);

    t_swbs_cmd w_cmd;
    t_swbs_sts w_sts;
    logic      w_req_ready;

    swbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_op        (i_req.op),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    swbs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (i_req.word),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_found     (o_rsp.found),
        .o_position  (o_rsp.position)
    );

    assign i_req.ready = w_req_ready;

endmodule

`default_nettype wire

// ----- bench/swbs_search_checker.sv -----
// checker for the sorted word binary search block: watches both channels,
// predicts each search result and compares it. depends on swbs_pkg and swbs_if
`timescale 1ns / 100ps

module swbs_search_checker import swbs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    swbs_req_if       i_req_mon,
    swbs_rsp_if       i_rsp_mon,
    output int        o_fail_count,
    output int        o_waiting
);

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_search_result;

    logic [WORD_W-1:0] dict_words [TABLE_DEPTH];
    int                dict_count;
    t_search_result    pending_results [$];
    t_search_result    want;
    logic [WORD_W-1:0] key;
    int                fail_count;

    initial begin
        fail_count   = 0;
        dict_count   = 0;
        o_fail_count = 0;
        o_waiting    = 0;
    end

    // probe sequence of the block: midpoint rounded down, first hit wins
    function automatic t_search_result lookup_word(input logic [WORD_W-1:0] w);
        t_search_result r;
        int lo;
        int hi;
        int mid;
        r  = '0;
        lo = 0;
        hi = dict_count - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (w < dict_words[mid]) begin
                hi = mid - 1;
            end else if (w > dict_words[mid]) begin
                lo = mid + 1;
            end else begin
                r.found    = 1'b1;
                r.position = mid[POS_W-1:0];
                break;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 100) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dict_count = 0;
            pending_results.delete();
        end else begin
            // a result leaving now belongs to an older search than any request taken now
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result with no search waiting: found %0b position %0d",
                                              i_rsp_mon.found, i_rsp_mon.position));
                end else begin
                    want = pending_results.pop_front();
                    if (i_rsp_mon.found !== want.found)
                        report_mismatch($sformatf("found is %0b, predicted %0b",
                                                  i_rsp_mon.found, want.found));
                    if (i_rsp_mon.position !== want.position)
                        report_mismatch($sformatf("position is %0d, predicted %0d",
                                                  i_rsp_mon.position, want.position));
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                key = i_req_mon.word & KEEP_MASK;
                case (i_req_mon.op)
                    OP_APPEND: begin
                        if (dict_count < TABLE_DEPTH) begin
                            dict_words[dict_count] = key;
                            dict_count++;
                        end
                    end
                    OP_SEARCH: pending_results.push_back(lookup_word(key));
                    OP_CLEAR:  dict_count = 0;
                    default:   ;
                endcase
            end
        end
        o_waiting    <= pending_results.size();
        o_fail_count <= fail_count;
    end

endmodule

// ----- bench/tb.sv -----
// testbench top for the sorted word binary search block: clock, reset,
// request and result stimulus, verdict. depends on swbs_pkg, swbs_if, swbs_search_checker
`timescale 1ns / 100ps

module tb import swbs_pkg::*; ();

    localparam int CLK_PERIOD       = 4;
    localparam int RESET_CYCLES     = 11;
    localparam int RANDOM_ITEMS     = 100;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 40;
    localparam int CYCLE_LIMIT      = 600000;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swbs_req_if req_ch ();
    swbs_rsp_if rsp_ch ();

    int fail_count;
    int results_waiting;
    int send_idle_pct     = 0;
    int stall_pct         = 0;
    int long_holds_asked  = 0;
    int long_holds_done   = 0;
    int requests_sent     = 0;
    int cycle_count       = 0;
    int phase_sel;
    int random_start;

    logic [WORD_W-1:0] loaded_words [$];

    sorted_word_binary_search_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    swbs_search_checker search_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_ch),
        .i_rsp_mon    (rsp_ch),
        .o_fail_count (fail_count),
        .o_waiting    (results_waiting)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off when one is asked for
    initial begin : result_drain
        int k;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_holds_asked != long_holds_done) begin
                rsp_ch.ready <= 1'b0;
                for (k = 1; k < LONG_HOLD_CYCLES; k++) @(posedge i_clk);
                long_holds_done++;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    function automatic logic [WORD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [WORD_W-1:0] pack_text(input string s);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < WORD_CHARS; i++) w[WORD_W-1-8*i -: 8] = s[i];
        return w;
    endfunction

    // loaded words more often than any other kind, some neighbors, extremes and noise
    function automatic logic [WORD_W-1:0] pick_search_key();
        logic [WORD_W-1:0] w;
        int n;
        n = loaded_words.size();
        w = (n > 0) ? loaded_words[$urandom_range(0, n - 1)] : random_word();
        case ($urandom_range(0, 9))
            4:       w = w + 64'd1;
            5:       w = w - 64'd1;
            6:       w = '0;
            7:       w = '1;
            8, 9:    w = random_word();
            default: ;
        endcase
        return w;
    endfunction

    // called right after a rising edge; returns right after the edge that took the request
    task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.word  <= w;
        forever begin
            @(negedge i_clk);
            if (req_ch.ready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (results_waiting != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 48; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 48; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
        endcase
    endtask

    // may clear, load ascending words (optionally with disorder and repeats), then search
    task automatic run_table_sequence(input int n_words, input int n_searches,
                                      input int stride_shift, input bit scrambled);
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] stride;
        int pick;
        if (n_words >= TABLE_DEPTH || $urandom_range(0, 9) != 0)
            send_request(OP_CLEAR, random_word());
        loaded_words.delete();
        w = ($urandom_range(0, 4) == 0) ? '0 : (random_word() >> 1);
        for (int i = 0; i < n_words; i++) begin
            if (scrambled && $urandom_range(0, 5) == 0) begin
                // out of order or a repeat of the last word
                if ($urandom_range(0, 1) == 0) w = random_word();
            end else if (i > 0) begin
                stride = ($urandom_range(0, 3) == 0) ? 64'd1
                                                     : (random_word() >> stride_shift) + 64'd1;
                w = w + stride;
            end
            send_request(OP_APPEND, w);
            loaded_words.push_back(w);
            if ($urandom_range(0, 24) == 0) send_request(OP_UNUSED, random_word());
            if ($urandom_range(0, 15) == 0) send_request(OP_SEARCH, pick_search_key());
        end
        for (int i = 0; i < n_searches; i++) begin
            pick = $urandom_range(0, 29);
            if (pick == 0)
                send_request(OP_CLEAR, random_word());
            else if (pick == 1)
                send_request(OP_UNUSED, random_word());
            else
                send_request(OP_SEARCH, pick_search_key());
        end
    endtask

    // results back up while the sender keeps offering searches
    task automatic squeeze_result_path();
        wait_for_results();
        long_holds_asked++;
        for (int i = 0; i < 12; i++) send_request(OP_SEARCH, pick_search_key());
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.op    <= OP_APPEND;
        req_ch.word  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, ignored op, extremes, text words, repeats, disorder
        send_request(OP_SEARCH, '0);
        send_request(OP_UNUSED, '1);
        send_request(OP_APPEND, '0);
        send_request(OP_APPEND, pack_text("ab"));
        send_request(OP_APPEND, pack_text("abc"));
        send_request(OP_APPEND, pack_text("b"));
        send_request(OP_APPEND, '1);
        send_request(OP_SEARCH, '0);
        send_request(OP_SEARCH, pack_text("abc"));
        send_request(OP_SEARCH, '1);
        send_request(OP_SEARCH, pack_text("abd"));
        send_request(OP_SEARCH, pack_text("a"));
        send_request(OP_SEARCH, pack_text("b"));
        send_request(OP_CLEAR, '0);
        send_request(OP_SEARCH, pack_text("ab"));
        send_request(OP_APPEND, pack_text("cat"));
        send_request(OP_APPEND, pack_text("cat"));
        send_request(OP_APPEND, pack_text("cat"));
        send_request(OP_SEARCH, pack_text("cat"));
        send_request(OP_SEARCH, pack_text("cow"));
        send_request(OP_CLEAR, '1);
        send_request(OP_APPEND, pack_text("oak"));
        send_request(OP_APPEND, pack_text("elm"));
        send_request(OP_APPEND, pack_text("yew"));
        send_request(OP_SEARCH, pack_text("elm"));
        send_request(OP_SEARCH, pack_text("yew"));

        // random: small tables under each idle pattern at least once
        random_start = requests_sent;
        phase_sel    = 0;
        while (requests_sent - random_start < RANDOM_ITEMS || phase_sel < 4) begin
            set_idling(phase_sel);
            phase_sel++;
            if ($urandom_range(0, 3) == 0)
                run_table_sequence($urandom_range(0, 4), $urandom_range(2, 8), 8,
                                   $urandom_range(0, 4) == 0);
            else
                run_table_sequence($urandom_range(5, 48), $urandom_range(4, 20), 8,
                                   $urandom_range(0, 4) == 0);
            if (phase_sel == 2) begin
                set_idling(0);
                squeeze_result_path();
            end
        end

        // one full table, a few appends past the end, then searches
        set_idling(3);
        run_table_sequence(TABLE_DEPTH + 4, 40, 12, 1'b0);
        set_idling(1);
        squeeze_result_path();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
